### src/cl2d_pkg.sv
`timescale 1ns / 1ps

package cl2d_pkg;

    // frame layout
    localparam int HEADER_BYTES    = 10;
    localparam int LINES_AT_OFFSET = 32;                       // power of two
    localparam int LINES_SHIFT     = $clog2(LINES_AT_OFFSET);
    localparam int OFFSET_LO_POS   = 2;
    localparam int OFFSET_HI_POS   = 3;

    // field and state widths
    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int POS_W   = 16;
    localparam int LIT_W   = 7;
    localparam int FILL_W  = 6;
    localparam int TOTAL_W = 23;
    localparam int WIDTH_W = 18;

    // command decoding
    localparam int LIT_LIMIT  = 65;    // 256 - cmd up to this is a literal count
    localparam int FILL_BASE  = 65;    // fill length is (256 - cmd) - this

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

    // one decoded result between decoder and output register
    typedef struct packed {
        logic               emit;
        logic [RUN_W-1:0]   run_length;
        logic [BYTE_W-1:0]  color_index;
        logic               is_transparent;
        logic               frame_end;
        logic [WIDTH_W-1:0] frame_width;
        logic               width_valid;
    } result_t;

endpackage

### src/cl2d_decode.sv
`timescale 1ns / 1ps

module cl2d_decode
    import cl2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              frame_last,
    output result_t           result
);

    typedef enum logic [1:0] {
        MODE_COMMAND = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_FILL    = 2'd2
    } mode_t;

    mode_t              mode_reg,   mode_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [LIT_W-1:0]   lit_reg,    lit_next;
    logic [FILL_W-1:0]  fill_reg,   fill_next;
    logic [TOTAL_W-1:0] total_reg,  total_next;
    logic [POS_W-1:0]   offset_reg, offset_next;
    logic [WIDTH_W-1:0] width_reg,  width_next;
    logic               seen_reg,   seen_next;

    logic [8:0]         neg_cmd;
    logic [8:0]         add_cnt;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] quot;
    logic [LIT_W-1:0]   lit_dec;
    logic [RUN_W-1:0]   run;
    logic [BYTE_W-1:0]  color;
    logic               trans;

    assign neg_cmd   = 9'd256 - {1'b0, data_byte};
    assign quot      = total_reg >> LINES_SHIFT;
    assign lit_dec   = (lit_reg != '0) ? lit_reg - LIT_W'(1) : lit_reg;
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(add_cnt);

    always_comb
    begin
        mode_next   = mode_reg;
        lit_next    = lit_reg;
        fill_next   = fill_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        seen_next   = seen_reg;
        add_cnt     = '0;
        run         = '0;
        color       = '0;
        trans       = 1'b0;

        if (pos_reg < POS_W'(HEADER_BYTES))
        begin
            if (pos_reg == POS_W'(OFFSET_LO_POS))
                offset_next[7:0] = data_byte;
            else if (pos_reg == POS_W'(OFFSET_HI_POS))
                offset_next[15:8] = data_byte;
        end
        else
        begin
            case (mode_reg)
                MODE_LITERAL:
                begin
                    run      = RUN_W'(1);
                    color    = data_byte;
                    lit_next = lit_dec;
                    if (lit_dec == '0)
                        mode_next = MODE_COMMAND;
                end
                MODE_FILL:
                begin
                    run       = RUN_W'(fill_reg);
                    color     = data_byte;
                    fill_next = '0;
                    mode_next = MODE_COMMAND;
                end
                default:
                begin
                    // width is taken from the total before this command
                    if (!seen_reg && pos_reg == offset_reg)
                    begin
                        width_next = (quot > TOTAL_W'(WIDTH_MAX)) ? WIDTH_MAX
                                                                : quot[WIDTH_W-1:0];
                        seen_next  = 1'b1;
                    end
                    if (!data_byte[7])
                    begin
                        run       = data_byte[RUN_W-1:0];
                        trans     = (data_byte != '0);
                        add_cnt   = {1'b0, data_byte};
                        mode_next = MODE_COMMAND;
                    end
                    else if (neg_cmd <= 9'(LIT_LIMIT))
                    begin
                        lit_next  = neg_cmd[LIT_W-1:0];
                        mode_next = MODE_LITERAL;
                        add_cnt   = neg_cmd;
                    end
                    else
                    begin
                        add_cnt   = neg_cmd - 9'(FILL_BASE);
                        fill_next = add_cnt[FILL_W-1:0];
                        mode_next = MODE_FILL;
                    end
                end
            endcase
        end

        total_next = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                      : total_sum[TOTAL_W-1:0];
        pos_next   = (pos_reg != '1) ? pos_reg + POS_W'(1) : pos_reg;

        result.emit           = (run != '0) || frame_last;
        result.run_length     = run;
        result.color_index    = color;
        result.is_transparent = trans;
        result.frame_end      = frame_last;
        result.frame_width    = (frame_last && seen_next) ? width_next : '0;
        result.width_valid    = frame_last && seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_COMMAND;
            pos_reg    <= '0;
            lit_reg    <= '0;
            fill_reg   <= '0;
            total_reg  <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            seen_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (frame_last)
            begin
                // next byte opens a new frame
                mode_reg   <= MODE_COMMAND;
                pos_reg    <= '0;
                lit_reg    <= '0;
                fill_reg   <= '0;
                total_reg  <= '0;
                offset_reg <= '0;
                width_reg  <= '0;
                seen_reg   <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                lit_reg    <= lit_next;
                fill_reg   <= fill_next;
                total_reg  <= total_next;
                offset_reg <= offset_next;
                width_reg  <= width_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

### src/cl2_rle_frame_decoder_core.sv
`timescale 1ns / 1ps

// run-length sprite frame decoder: takes one compressed byte per beat on the
// slave stream, header included, with tlast on the final byte of the frame,
// and returns one beat per pixel run on the master stream (transparent runs,
// single literal palette indices and fill runs). zero-length transparent
// commands, header bytes and the command bytes that open a literal or fill run
// produce no beat unless they close the frame; a fill command cut off by the
// frame end yields no run. the beat for the frame's
// last byte carries tlast and, in its width field, the pixel total at the
// header's line offset divided by the line count, with a valid flag that is
// low when that offset never landed on a command byte. throughput is one byte
// per clock while the master side accepts: a byte waits in the input register
// while the single decode stage updates its small mode and count registers,
// and its result is written to the output register, from which the result
// beat is presented on the master side. stalls on the master side hold
// both registers, and the slave side keeps accepting as long as the input
// register can move on.
module cl2_rle_frame_decoder_core
    import cl2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // frame_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [6:0] run_length, [14:7] color_index,
                                   // [32:15] frame_width, [39:33] zero
    output logic [1:0]  m_tuser,   // [0] is_transparent, [1] width_valid
    output logic        m_tlast    // frame_end
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    logic    advance;
    logic    load_out;
    result_t dec_result;

    // the decode stage moves whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign load_out = advance && dec_result.emit;
    assign s_tready = !in_valid_reg || advance;

    cl2d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .data_byte  (in_data_reg),
        .frame_last (in_last_reg),
        .result     (dec_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (load_out)
            out_reg <= dec_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.frame_width, out_reg.color_index, out_reg.run_length};
    assign m_tuser  = {out_reg.width_valid, out_reg.is_transparent};
    assign m_tlast  = out_reg.frame_end;

`ifndef ASSERT_OFF
    // every beat is either a real run or the frame end report
    a_no_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] != 7'd0) || m_tlast)
        else $error("empty run beat without frame end");

    // width is only reported with the frame end
    a_width_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("width valid outside frame end");

    // transparent runs carry no color and are never empty
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[14:7] == 8'd0) && (m_tdata[6:0] != 7'd0))
        else $error("bad transparent run");

    // an empty input register always takes a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stall with empty input register");
`endif

endmodule
